// ===== rtl/core/adsf_pkg.sv =====
// Shared types and constants for the article dot-stuffing framer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package adsf_pkg;

  localparam int BYTE_W    = 8;
  localparam int MAX_LINE  = 505;
  localparam int LC_W      = $clog2(MAX_LINE + 1);
  localparam int MAX_RUN   = 7;
  localparam int RUN_LEN_W = $clog2(MAX_RUN + 1);

  localparam logic [BYTE_W-1:0] CH_DOT = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [1:0] {
    MODE_ARTICLE = 2'd0,
    MODE_HEAD    = 2'd1,
    MODE_BODY    = 2'd2,
    MODE_STAT    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_HEAD = 3'b001,
    PH_BODY = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  // Result bytes of one input item, first byte in entry 0.
  typedef struct packed {
    logic [MAX_RUN-1:0][BYTE_W-1:0] bytes;
    logic [RUN_LEN_W-1:0]           len;
    logic                           term;
  } run_t;

endpackage

`default_nettype wire

// ===== rtl/core/adsf_ifs.sv =====
// Channel interfaces of the framer: article input, text output, mode write.
// Depends on adsf_pkg for field widths.
`default_nettype none

interface adsf_item_if import adsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] data_byte;

  modport source(output valid, kind, data_byte, input ready);
  modport sink(input valid, kind, data_byte, output ready);
endinterface

interface adsf_text_if import adsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              article_end;

  modport source(output valid, out_byte, run_last, article_end, input ready);
  modport sink(input valid, out_byte, run_last, article_end, output ready);
endinterface

interface adsf_cfg_if import adsf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] mode;

  modport source(output valid, mode, input ready);
  modport sink(input valid, mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/article_dot_stuff_framer.sv =====
// An accepted article beat passes the input register, then the result register.
// Throughput: one article beat per cycle while each yields at most one byte and the
// output is not stalled; a beat yielding more bytes (at most 7) holds the input until
// the result register, sending one byte per cycle unless stalled, is on its last byte.
// Reset: mode whole article, header phase, line empty, input and result registers empty.
// Top level; depends on adsf_pkg, adsf_ifs, adsf_expand and adsf_emit.
`default_nettype none

module article_dot_stuff_framer import adsf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  adsf_item_if.sink   article,
  adsf_text_if.source text,
  adsf_cfg_if.sink    cfg
);

  mode_t             mode;
  logic              item_valid;
  logic              item_kind;
  logic [BYTE_W-1:0] item_byte;
  logic              accept;
  logic              advance;
  logic              can_load;
  run_t              run;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ARTICLE;
    end else if (cfg.valid) begin
      mode <= mode_t'(cfg.mode);
    end
  end

  // an item with no output never waits for the result register
  assign advance       = item_valid && (run.len == '0 || can_load);
  assign article.ready = !item_valid || advance;
  assign accept        = article.valid && article.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind <= article.kind;
      item_byte <= article.data_byte;
    end
  end

  adsf_expand u_expand (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .kind      (item_kind),
    .data_byte (item_byte),
    .mode      (mode),
    .run       (run)
  );

  adsf_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && run.len != '0),
    .run_in   (run),
    .can_load (can_load),
    .text     (text)
  );

endmodule

`default_nettype wire

// ===== rtl/core/adsf_expand.sv =====
// Expands one registered article item into its run of text bytes and keeps
// the header/body phase and line length. Depends on adsf_pkg.
`default_nettype none

module adsf_expand import adsf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic              kind,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire mode_t             mode,
  output run_t                   run
);

  phase_t               phase, phase_next;
  logic [LC_W-1:0]      line_count, line_count_next;
  logic [RUN_LEN_W-1:0] n;
  logic                 send;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEAD;
      line_count <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      line_count <= line_count_next;
    end
  end

  always_comb begin
    run             = '0;
    n               = '0;
    phase_next      = phase;
    line_count_next = line_count;
    send = ((phase == PH_HEAD) && (mode == MODE_ARTICLE || mode == MODE_HEAD)) ||
           ((phase == PH_BODY) && (mode == MODE_ARTICLE || mode == MODE_BODY));

    if (kind == KIND_END) begin
      // close a sent open line; in article mode add the empty line if the body never began
      if (phase != PH_DONE && line_count != '0 && send) begin
        run.bytes[n]                  = CH_CR;
        run.bytes[n + RUN_LEN_W'(1)]  = CH_LF;
        n = n + RUN_LEN_W'(2);
      end
      if (phase == PH_HEAD && mode == MODE_ARTICLE) begin
        run.bytes[n]                  = CH_CR;
        run.bytes[n + RUN_LEN_W'(1)]  = CH_LF;
        n = n + RUN_LEN_W'(2);
      end
      if (phase != PH_DONE && mode != MODE_STAT) begin
        run.bytes[n]                  = CH_DOT;
        run.bytes[n + RUN_LEN_W'(1)]  = CH_CR;
        run.bytes[n + RUN_LEN_W'(2)]  = CH_LF;
        n = n + RUN_LEN_W'(3);
        run.term = 1'b1;
      end
      phase_next      = PH_HEAD;
      line_count_next = '0;
    end else if (phase != PH_DONE) begin
      if (data_byte == CH_LF) begin
        if (phase == PH_HEAD && line_count == '0) begin
          // empty line: end of header
          unique case (mode)
            MODE_ARTICLE: begin
              run.bytes[0] = CH_CR;
              run.bytes[1] = CH_LF;
              n = RUN_LEN_W'(2);
              phase_next = PH_BODY;
            end
            MODE_HEAD: begin
              run.bytes[0] = CH_DOT;
              run.bytes[1] = CH_CR;
              run.bytes[2] = CH_LF;
              n = RUN_LEN_W'(3);
              run.term = 1'b1;
              phase_next = PH_DONE;
            end
            default: begin
              phase_next = PH_BODY;
            end
          endcase
        end else if (send) begin
          run.bytes[0] = CH_CR;
          run.bytes[1] = CH_LF;
          n = RUN_LEN_W'(2);
        end
        line_count_next = '0;
      end else if (line_count < LC_W'(MAX_LINE)) begin
        if (send) begin
          if (line_count == '0 && data_byte == CH_DOT) begin
            run.bytes[n] = CH_DOT;
            n = n + RUN_LEN_W'(1);
          end
          run.bytes[n] = data_byte;
          n = n + RUN_LEN_W'(1);
        end
        line_count_next = line_count + LC_W'(1);
      end
      // drop characters beyond the line limit
    end
    run.len = n;
  end

endmodule

`default_nettype wire

// ===== rtl/core/adsf_emit.sv =====
// Result register of the framer: holds one run of text bytes and shifts
// it out a beat at a time. Depends on adsf_pkg and adsf_text_if.
`default_nettype none

module adsf_emit import adsf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire run_t       run_in,
  output logic            can_load,
  adsf_text_if.source     text
);

  run_t run_q;
  logic beat;

  assign beat     = text.valid && text.ready;
  assign can_load = (run_q.len == '0) || (run_q.len == RUN_LEN_W'(1) && text.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_q.len <= '0;
    end else if (load) begin
      run_q.len <= run_in.len;
    end else if (beat) begin
      run_q.len <= run_q.len - RUN_LEN_W'(1);
    end
    // payload: load a fresh run or advance to the next byte
    if (load) begin
      run_q.bytes <= run_in.bytes;
      run_q.term  <= run_in.term;
    end else if (beat) begin
      run_q.bytes <= run_q.bytes >> BYTE_W;
    end
  end

  assign text.valid       = run_q.len != '0;
  assign text.out_byte    = run_q.bytes[0];
  assign text.run_last    = run_q.len == RUN_LEN_W'(1);
  assign text.article_end = run_q.term && (run_q.len == RUN_LEN_W'(1));

endmodule

`default_nettype wire

// ===== rtl/core/adsf_checker.sv =====
// Port-level checks for the framer, bound to the top level.
// Depends on article_dot_stuff_framer and its interface ports.
`default_nettype none

module adsf_checker import adsf_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] out_byte,
  input wire logic              run_last,
  input wire logic              article_end
);

  // terminator LF always closes the run of its end marker
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && article_end |-> run_last)
    else $error("article_end without run_last");

  a_end_is_lf: assert property (@(posedge clk) disable iff (rst)
    out_valid && article_end |-> out_byte == CH_LF)
    else $error("article_end on a byte other than LF");

  // the byte before the terminator LF is CR
  a_cr_before_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !article_end ##1 out_valid && article_end
    |-> $past(out_byte) == CH_CR)
    else $error("terminator LF not preceded by CR");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("text beat offered straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("stalled text beat changed");

endmodule

bind article_dot_stuff_framer adsf_checker u_adsf_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (text.valid),
  .out_ready   (text.ready),
  .out_byte    (text.out_byte),
  .run_last    (text.run_last),
  .article_end (text.article_end)
);

`default_nettype wire
